### hdl/hostname_pattern_blocker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the host name pattern blocker.
// ----------------------------------------------------------------------------
`ifndef HOSTNAME_PATTERN_BLOCKER_MACROS_SVH
`define HOSTNAME_PATTERN_BLOCKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hpb_pkg.sv
// ----------------------------------------------------------------------------
// hpb_pkg
// Shared types and constants of the host name pattern blocker.
// ----------------------------------------------------------------------------
package hpb_pkg;

    localparam int NUM_PATTERNS    = 64;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int IDX_W  = $clog2(NUM_PATTERNS);
    localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CNT_W  = $clog2(NUM_PATTERNS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Request codes as they arrive on the stream.
    localparam logic [1:0] REQ_PAT_BYTE = 2'd0;
    localparam logic [1:0] REQ_PAT_LEN  = 2'd1;
    localparam logic [1:0] REQ_HOST     = 2'd2;

    // Configuration register indexes.
    localparam logic REG_PATTERN_COUNT = 1'b0;
    localparam logic REG_FIRST_FILTER  = 1'b1;

    typedef enum logic [1:0] {
        CMD_PAT_BYTE,
        CMD_PAT_LEN,
        CMD_HOST
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   idx;
        logic [POS_W-1:0]   pos;
        logic [LEN_W-1:0]   len;
        logic [7:0]         data;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic idle;
        logic scanning;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } back_state_t;

    // True for a byte allowed to open a pattern when filtering is on.
    function automatic logic lead_ok(input logic [7:0] c);
        lead_ok = (c == 8'h2E) || (c == 8'h2D) || (c == 8'h5F) ||
                  ((c >= 8'h31) && (c <= 8'h39)) ||
                  ((c >= 8'h41) && (c <= 8'h5A)) ||
                  ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

### hdl/hpb_front.sv
// ----------------------------------------------------------------------------
// hpb_front
// Accepts request transfers, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module hpb_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    output hpb_pkg::cmd_t        head,
    output logic                 head_valid,
    input  logic                 pop
);

    hpb_pkg::cmd_t                 queue_reg [hpb_pkg::QUEUE_DEPTH];
    logic [hpb_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [hpb_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [hpb_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [hpb_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [hpb_pkg::QCNT_W-1:0]    count_reg;
    logic [hpb_pkg::QCNT_W-1:0]    count_next;
    hpb_pkg::cmd_t                 cmd;
    logic                          accept;
    logic                          push;
    logic [hpb_pkg::LEN_W-1:0]     raw_len;

    // Decode the transfer into a queued command; lengths are clamped here.
    always_comb
    begin
        raw_len   = s_tdata[16:11];
        cmd.idx   = s_tdata[5:0];
        cmd.pos   = s_tdata[10:6];
        cmd.len   = (raw_len > hpb_pkg::LEN_W'(hpb_pkg::MAX_PATTERN_LEN)) ?
                    hpb_pkg::LEN_W'(hpb_pkg::MAX_PATTERN_LEN) : raw_len;
        cmd.data  = s_tdata[24:17];
        cmd.last  = s_tlast;
        case (s_tuser)
            hpb_pkg::REQ_PAT_BYTE: cmd.kind = hpb_pkg::CMD_PAT_BYTE;
            hpb_pkg::REQ_PAT_LEN:  cmd.kind = hpb_pkg::CMD_PAT_LEN;
            default:               cmd.kind = hpb_pkg::CMD_HOST;
        endcase
    end

    assign s_tready = (count_reg != hpb_pkg::QCNT_W'(hpb_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;
    // Unknown request codes are accepted and dropped.
    assign push     = accept && (s_tuser == hpb_pkg::REQ_PAT_BYTE ||
                                 s_tuser == hpb_pkg::REQ_PAT_LEN ||
                                 s_tuser == hpb_pkg::REQ_HOST);

    assign head       = queue_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);

    // Queue pointer and fill arithmetic.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + hpb_pkg::QCNT_W'(push) - hpb_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

### hdl/hpb_back.sv
// ----------------------------------------------------------------------------
// hpb_back
// Pattern table, host byte window and the row-by-row pattern scan.
// ----------------------------------------------------------------------------
module hpb_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  hpb_pkg::cmd_t                head,
    input  logic                         head_valid,
    output logic                         pop,
    input  logic [hpb_pkg::CNT_W-1:0]    pattern_count,
    input  logic                         first_char_filter,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,
    output hpb_pkg::back_status_t        status
);

    localparam int NP = hpb_pkg::NUM_PATTERNS;
    localparam int ML = hpb_pkg::MAX_PATTERN_LEN;

    // Pattern table memories.
    logic [7:0]                    row_mem [NP][ML];
    logic [hpb_pkg::LEN_W-1:0]     len_mem [NP];
    logic [7:0]                    row_q [ML];
    logic [hpb_pkg::LEN_W-1:0]     len_q;

    hpb_pkg::back_state_t          state_reg;
    hpb_pkg::back_state_t          state_next;
    logic [hpb_pkg::CNT_W-1:0]     p_reg;
    logic [hpb_pkg::CNT_W-1:0]     p_next;
    logic                          rd_valid_reg;
    logic                          rd_valid_next;
    logic [7:0]                    win_reg [ML];
    logic [hpb_pkg::LEN_W-1:0]     seen_reg;
    logic [hpb_pkg::LEN_W-1:0]     seen_next;
    logic                          match_reg;
    logic                          match_next;
    logic                          last_reg;
    logic                          last_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_bit_reg;

    logic [hpb_pkg::CNT_W-1:0]     active;
    logic                          issue;
    logic                          hit;
    logic                          scan_done;
    logic                          take_host;
    logic                          out_load;
    logic                          row_we;
    logic                          len_we;
    logic [hpb_pkg::POS_W-1:0]     tap;

    assign active = (pattern_count > hpb_pkg::CNT_W'(NP)) ?
                    hpb_pkg::CNT_W'(NP) : pattern_count;

    // Compare the fetched row with the newest bytes, pattern end at newest.
    always_comb
    begin
        hit = rd_valid_reg && (len_q <= seen_reg);
        if (first_char_filter && ((len_q == '0) || !hpb_pkg::lead_ok(row_q[0])))
        begin
            hit = 1'b0;
        end
        for (int j = 0; j < ML; j++)
        begin
            tap = hpb_pkg::POS_W'(len_q - hpb_pkg::LEN_W'(j) - 1'b1);
            if ((hpb_pkg::LEN_W'(j) < len_q) && (row_q[j] != win_reg[tap]))
            begin
                hit = 1'b0;
            end
        end
    end

    // Scan control.
    always_comb
    begin
        issue     = (state_reg == hpb_pkg::ST_SCAN) && (p_reg < active) &&
                    !match_reg && !hit;
        scan_done = (state_reg == hpb_pkg::ST_SCAN) && !rd_valid_reg && !issue;
        out_load  = (state_reg == hpb_pkg::ST_RESULT) && (!out_valid_reg || m_tready);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpb_pkg::ST_IDLE:
            begin
                if (head_valid && head.kind == hpb_pkg::CMD_HOST)
                begin
                    state_next = hpb_pkg::ST_SCAN;
                end
            end
            hpb_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = last_reg ? hpb_pkg::ST_RESULT : hpb_pkg::ST_IDLE;
                end
            end
            hpb_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = hpb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hpb_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        pop            = 1'b0;
        row_we         = 1'b0;
        len_we         = 1'b0;
        take_host      = 1'b0;
        p_next         = p_reg;
        rd_valid_next  = issue;
        seen_next      = seen_reg;
        match_next     = match_reg || hit;
        last_next      = last_reg;
        out_valid_next = (m_tvalid && m_tready) ? 1'b0 : out_valid_reg;
        case (state_reg)
            hpb_pkg::ST_IDLE:
            begin
                pop = head_valid;
                if (head_valid)
                begin
                    case (head.kind)
                        hpb_pkg::CMD_PAT_BYTE: row_we = 1'b1;
                        hpb_pkg::CMD_PAT_LEN:  len_we = 1'b1;
                        default:
                        begin
                            take_host = 1'b1;
                            last_next = head.last;
                            p_next    = '0;
                            if (seen_reg < hpb_pkg::LEN_W'(ML))
                            begin
                                seen_next = seen_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            hpb_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            hpb_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    seen_next      = '0;
                    match_next     = 1'b0;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpb_pkg::ST_IDLE;
            p_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            seen_reg      <= '0;
            match_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            rd_valid_reg  <= rd_valid_next;
            seen_reg      <= seen_next;
            match_reg     <= match_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Table writes and registered row read.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[head.idx][head.pos] <= head.data;
        end
        if (len_we)
        begin
            len_mem[head.idx] <= head.len;
        end
        row_q <= row_mem[p_reg[hpb_pkg::IDX_W-1:0]];
        len_q <= len_mem[p_reg[hpb_pkg::IDX_W-1:0]];
    end

    // Host byte window, newest byte first; bytes past the count are never compared.
    always_ff @(posedge clk)
    begin
        if (take_host)
        begin
            win_reg[0] <= head.data;
            for (int k = 1; k < ML; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        if (out_load)
        begin
            out_bit_reg <= match_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {7'b0, out_bit_reg};
    assign status.idle     = (state_reg == hpb_pkg::ST_IDLE);
    assign status.scanning = (state_reg == hpb_pkg::ST_SCAN);

endmodule

### hdl/hostname_pattern_blocker.sv
// ----------------------------------------------------------------------------
// hostname_pattern_blocker
// Reports whether any loaded pattern occurs as a substring of a host name.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         pattern byte, pattern length and host byte requests
//  m_*       out        is_ad, one transfer per host name
//  cfg_*     in         pattern_count and first_char_filter writes
//
//  The back end applies a table write from its idle state. A host byte is
//  compared against the first pattern_count rows (the count being capped at
//  64) through the single read port of the pattern row memory, which is
//  scanned one row per cycle; the scan stops early on a hit. No clearing pass
//  follows reset. A four-entry queue lets requests be taken while the back end
//  scans or a result is stalled.
// ----------------------------------------------------------------------------
`include "hostname_pattern_blocker_macros.svh"

module hostname_pattern_blocker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] pattern_index, [10:6] byte_pos, [16:11] pattern_length,
    // [24:17] data_byte, [31:25] zero
    input  logic [31:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] is_ad, [7:1] zero
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    hpb_pkg::cmd_t                 head;
    logic                          head_valid;
    logic                          pop;
    hpb_pkg::back_status_t         status;
    logic [hpb_pkg::CNT_W-1:0]     pattern_count_reg;
    logic                          filter_reg;

    // Configuration registers take every transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_count_reg <= '0;
            filter_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hpb_pkg::REG_PATTERN_COUNT: pattern_count_reg <= cfg_data;
                hpb_pkg::REG_FIRST_FILTER:  filter_reg <= cfg_data[0];
                default:                    filter_reg <= filter_reg;
            endcase
        end
    end

    hpb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    hpb_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .head_valid        (head_valid),
        .pop               (pop),
        .pattern_count     (pattern_count_reg),
        .first_char_filter (filter_reg),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .status            (status)
    );

    // The back end only takes commands that are in the queue.
    `HPB_ASSERT_NOW(a_pop_needs_head, pop, head_valid && status.idle, "pop from empty queue")
    // A host byte taken from the queue always starts a scan.
    `HPB_ASSERT_NEXT(a_host_starts_scan, pop && head.kind == hpb_pkg::CMD_HOST, status.scanning, "host byte did not start scan")
    // A scan never starts while the back end is busy elsewhere.
    `HPB_ASSERT_NEXT(a_scan_from_idle, !status.scanning && !status.idle, !status.scanning, "scan entered from result state")

endmodule

### verif/tb_hostname_pattern_blocker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hostname_pattern_blocker
// Self-checking bench for the host name pattern blocker.
// ----------------------------------------------------------------------------
// The pattern table is loaded, then host names are streamed through with
// random content. Many hosts have a stored pattern planted in them, and table
// writes, ignored requests and register changes are mixed in. A scoreboard
// keeps its own copy of the table and the host window, and works out the
// verdict due for every host. Every verdict that leaves the block is checked
// against it in order. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_hostname_pattern_blocker;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 8;
    localparam int NP           = hpb_pkg::NUM_PATTERNS;
    localparam int ML           = hpb_pkg::MAX_PATTERN_LEN;

    // Keeps the table and the host window, and the verdicts still owed.
    class host_verdict_board;
        logic [7:0] rows [NP][ML];
        int         lens [NP];
        logic [7:0] recent [ML];
        int         seen;
        bit         hit;
        int         active_count;
        bit         filter_on;
        bit         verdicts_due [$];
        int         errors;

        function new();
            foreach (rows[p, k]) rows[p][k] = 8'h00;
            foreach (lens[p]) lens[p] = 0;
            foreach (recent[k]) recent[k] = 8'h00;
            seen = 0;
            hit = 0;
            active_count = 0;
            filter_on = 0;
            errors = 0;
        endfunction

        function bit is_lead_byte(logic [7:0] c);
            return c == "." || c == "-" || c == "_" || (c >= "1" && c <= "9") ||
                   (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        // True when pattern p ends exactly at the newest host byte.
        function bit ends_here(int p);
            int n;
            n = lens[p];
            if (filter_on && (n == 0 || !is_lead_byte(rows[p][0])))
                return 0;
            if (n > seen)
                return 0;
            for (int k = 0; k < n; k++)
                if (rows[p][n - 1 - k] != recent[k])
                    return 0;
            return 1;
        endfunction

        function void write_register(logic index, logic [6:0] value);
            if (index == hpb_pkg::REG_PATTERN_COUNT)
                active_count = (int'(value) > NP) ? NP : int'(value);
            else
                filter_on = value[0];
        endfunction

        function void note_request(logic [1:0] kind, logic [5:0] idx, logic [4:0] pos,
                                   logic [5:0] len, logic [7:0] data, logic last);
            if (kind == hpb_pkg::REQ_PAT_BYTE)
            begin
                rows[idx][pos] = data;
            end
            else if (kind == hpb_pkg::REQ_PAT_LEN)
            begin
                lens[idx] = (int'(len) > ML) ? ML : int'(len);
            end
            else if (kind == hpb_pkg::REQ_HOST)
            begin
                for (int k = ML - 1; k > 0; k--)
                    recent[k] = recent[k - 1];
                recent[0] = data;
                if (seen < ML)
                    seen++;
                for (int p = 0; p < active_count && !hit; p++)
                    if (ends_here(p))
                        hit = 1;
                if (last)
                begin
                    verdicts_due.push_back(hit);
                    foreach (recent[k]) recent[k] = 8'h00;
                    seen = 0;
                    hit = 0;
                end
            end
        endfunction

        function void check_verdict(bit actual);
            bit wanted;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected verdict transfer: is_ad=%0d", actual);
                return;
            end
            wanted = verdicts_due.pop_front();
            if (wanted != actual)
            begin
                errors++;
                if (errors <= 10)
                    $display("is_ad mismatch: expected %0d, got %0d", wanted, actual);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    host_verdict_board board = new();
    bit   calm;
    int   cycles;
    bit   byte_written [NP][ML];
    string alphabet = "ab.-_1Z";

    hostname_pattern_blocker uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Cycle count and timeout.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stalls at random outside the calm stretch.
    always @(negedge clk)
    begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
    end

    // Check each verdict transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_verdict(m_tdata[0]);
    end

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return alphabet[r];
        if (r == 7)
            return 8'h00;
        if (r == 8)
            return "!";
        return 8'($urandom_range(255));
    endfunction

    // Number of bytes written from position zero up, unbroken.
    function automatic int written_run(int idx);
        int n;
        n = 0;
        while (n < ML && byte_written[idx][n])
            n++;
        return n;
    endfunction

    // One transfer on the request stream.
    task automatic send_req(logic [1:0] kind, logic [5:0] idx, logic [4:0] pos,
                            logic [5:0] len, logic [7:0] data, logic last);
        bit gap;
        gap = !calm && ($urandom_range(99) < 21);
        if (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {7'd0, data, len, pos, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_request(kind, idx, pos, len, data, last);
    endtask

    task automatic write_pattern_byte(int idx, int pos, logic [7:0] data);
        send_req(hpb_pkg::REQ_PAT_BYTE, 6'(idx), 5'(pos), 6'($urandom_range(63)), data,
                 1'($urandom_range(1)));
        byte_written[idx][pos] = 1;
    endtask

    // A random table write that never makes an unwritten byte comparable.
    task automatic random_table_write();
        int idx;
        int run;
        int len;
        idx = $urandom_range(NP - 1);
        run = written_run(idx);
        if ($urandom_range(2) == 0)
        begin
            len = (run == ML) ? $urandom_range(63) : $urandom_range(run);
            if (len == 0 && $urandom_range(3) != 0)
                len = run;
            send_req(hpb_pkg::REQ_PAT_LEN, 6'(idx), 5'($urandom_range(31)), 6'(len),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        else
        begin
            write_pattern_byte(idx, (run < ML && $urandom_range(1)) ?
                               run : $urandom_range(ML - 1), pick_byte());
        end
    endtask

    // Stream one host name, often with an active pattern planted in it.
    task automatic send_host(int host_len, bit mix_table);
        logic [7:0] host [];
        int p;
        int n;
        int at;
        host = new[host_len];
        foreach (host[k]) host[k] = pick_byte();
        if (board.active_count > 0 && $urandom_range(1))
        begin
            p = $urandom_range(board.active_count - 1);
            n = board.lens[p];
            if (n <= host_len)
            begin
                at = $urandom_range(host_len - n);
                for (int k = 0; k < n; k++)
                    host[at + k] = board.rows[p][k];
            end
        end
        foreach (host[k])
        begin
            if (mix_table && $urandom_range(99) < 3)
                random_table_write();
            send_req(hpb_pkg::REQ_HOST, 6'($urandom_range(63)), 5'($urandom_range(31)),
                     6'($urandom_range(63)), host[k], k == host_len - 1);
        end
    endtask

    // Register writes only once the block has gone quiet.
    task automatic set_registers(int count, bit filter);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.verdicts_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int r = 0; r < 2; r++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? hpb_pkg::REG_PATTERN_COUNT : hpb_pkg::REG_FIRST_FILTER;
            cfg_data  <= (r == 0) ? 7'(count) : 7'(filter);
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            board.write_register((r == 0) ? hpb_pkg::REG_PATTERN_COUNT
                                          : hpb_pkg::REG_FIRST_FILTER,
                                 (r == 0) ? 7'(count) : 7'(filter));
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        int len;
        int done;
        int counts [NUM_PHASES] = '{0, 64, 127, 17, 64, 33, 1, 127};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = hpb_pkg::REQ_PAT_BYTE;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = hpb_pkg::REG_PATTERN_COUNT;
        cfg_data  = '0;
        calm      = 1'b0;
        cycles    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Load every entry: short patterns, one empty, two full-length.
        for (int p = 0; p < NP; p++)
        begin
            len = (p == 5) ? 0 : (p >= 62) ? ML : $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
                write_pattern_byte(p, k, (p == 0 && k == 0) ? "!" : pick_byte());
            // The oversized length on entry 62 is stored as the maximum.
            send_req(hpb_pkg::REQ_PAT_LEN, 6'(p), 5'd31, (p == 62) ? 6'd63 : 6'(len),
                     8'hFF, 1'b0);
        end

        // Directed: empty pattern excluded, zero bytes, an ignored request.
        set_registers(5, 0);
        send_req(2'd3, 6'd63, 5'd31, 6'd63, 8'hFF, 1'b1);
        send_host(3, 0);
        send_req(hpb_pkg::REQ_HOST, 6'd0, 5'd0, 6'd0, 8'h00, 1'b0);
        send_req(hpb_pkg::REQ_HOST, 6'd0, 5'd0, 6'd0, 8'hFF, 1'b1);
        send_host(6, 0);
        // Empty pattern active with the filter off: always a hit.
        set_registers(6, 0);
        send_host(1, 0);
        // Filter on over the full table, long hosts that hold a full pattern.
        set_registers(64, 1);
        for (int h = 0; h < 2; h++)
        begin
            for (int k = 0; k < 4; k++)
                send_req(hpb_pkg::REQ_HOST, 6'd0, 5'd0, 6'd0, pick_byte(), 1'b0);
            for (int k = 0; k < ML; k++)
                send_req(hpb_pkg::REQ_HOST, 6'd0, 5'd0, 6'd0, board.rows[62 + h][k], 1'b0);
            send_req(hpb_pkg::REQ_HOST, 6'd0, 5'd0, 6'd0, "x", 1'b1);
        end
        // Count beyond the table size.
        set_registers(127, 1);
        send_host(2, 0);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_registers(counts[ph], 1'($urandom_range(1)));
            calm = (ph == 4);
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 15)
                begin
                    random_table_write();
                    done++;
                end
                else if ($urandom_range(99) < 3)
                begin
                    send_req(2'd3, 6'($urandom_range(63)), 5'($urandom_range(31)),
                             6'($urandom_range(63)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
                end
                else
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(33, 70)
                                                   : $urandom_range(1, 12);
                    send_host(len, 1);
                    done += len;
                end
            end
        end
        calm = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain, then allow for any stray transfer.
        while (board.verdicts_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
